### rtl/core/double_ended_queue_assert.svh
// ============================================================================
// double_ended_queue_assert.svh
// Assertion macros for the double-ended queue.
// Each macro is given the clock and the active-low reset as arguments.
// ============================================================================
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define DQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("double_ended_queue: check failed");

// The consequent must hold in the cycle after the antecedent.
`define DQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("double_ended_queue: check failed");

`else

`define DQ_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define DQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### rtl/core/dq_pkg.sv
// ============================================================================
// dq_pkg
// Types and constants shared by the double-ended queue.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package dq_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int DATA_W        = 32;

    typedef enum logic [1:0] {
        ACT_APPEND = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_LIST   = 2'd3
    } dq_action_t;

    typedef enum logic [2:0] {
        STAT_DONE    = 3'd0,
        STAT_FULL    = 3'd1,
        STAT_EMPTY   = 3'd2,
        STAT_ELEMENT = 3'd3,
        STAT_NOLIST  = 3'd4
    } dq_status_t;

    typedef enum logic {
        STATE_IDLE = 1'b0,
        STATE_LIST = 1'b1
    } dq_state_t;

    typedef struct packed {
        dq_action_t                 action;
        logic signed [DATA_W-1:0]   item_value;
    } dq_cmd_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]   out_value;
        dq_status_t                 status;
        logic                       last;
    } dq_res_t;

endpackage

`default_nettype wire

### rtl/core/double_ended_queue.sv
// ============================================================================
// double_ended_queue
// Bounded double-ended queue of signed 32-bit values in a circular RAM.
// Append, insert, remove and list actions with per-transfer status results.
// ============================================================================
//
//  channel   direction  handshake                 payload
//  cmd       in         cmd_valid / cmd_stall      dq_cmd_t (action, item_value)
//  res       out        res_valid / res_stall      dq_res_t (out_value, status, last)
//
//  Append, insert and remove are taken one command per cycle while cmd_stall is low.
//  A listing of N elements streams one element per cycle from the RAM read
//  port while res_stall is low; the next command is taken once the tail
//  element has reached the output register.
//  Reset empties the queue at once; RAM contents are not cleared.
//  A stalled result holds the output register, and with it the listing.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

`include "double_ended_queue_assert.svh"

module double_ended_queue #(
    parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cmd_valid,
    output logic                cmd_stall,
    input  wire dq_pkg::dq_cmd_t cmd,
    output logic                res_valid,
    input  wire logic           res_stall,
    output dq_pkg::dq_res_t     res
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    dq_pkg::dq_state_t state_reg, state_next;
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic              rd_valid_reg, rd_valid_next;
    logic              rd_last_reg, rd_last_next;
    dq_pkg::dq_res_t   out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    logic                       out_free;
    logic                       accept;
    logic                       is_full;
    logic                       is_empty;
    logic                       move;
    logic                       list_start;
    logic                       push_ok;
    logic                       pop_ok;
    logic                       stat_load;
    dq_pkg::dq_status_t         stat_code;
    logic [SUM_W-1:0]           tail_sum;
    logic [PTR_W-1:0]           tail_pos;
    logic [PTR_W-1:0]           head_dec;
    logic [PTR_W-1:0]           head_inc;
    logic [PTR_W-1:0]           rd_ptr_inc;
    logic                       wr_en;
    logic [PTR_W-1:0]           wr_addr;
    logic                       rd_en;
    logic [PTR_W-1:0]           rd_addr;
    logic                       issue_last;
    logic [dq_pkg::DATA_W-1:0]  rd_data;

    dq_ram #(
        .WIDTH (dq_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (cmd.item_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // pointer arithmetic, modulo DEPTH
    always_comb
    begin
        tail_sum = SUM_W'(head_reg) + SUM_W'(count_reg);
        if (tail_sum >= SUM_W'(DEPTH))
        begin
            tail_pos = PTR_W'(tail_sum - SUM_W'(DEPTH));
        end
        else
        begin
            tail_pos = PTR_W'(tail_sum);
        end
        head_dec   = (head_reg == '0) ? PTR_W'(DEPTH - 1) : head_reg - PTR_W'(1);
        head_inc   = (head_reg == PTR_W'(DEPTH - 1)) ? '0 : head_reg + PTR_W'(1);
        rd_ptr_inc = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
    end

    // control outputs
    always_comb
    begin
        out_free   = !out_valid_reg || !res_stall;
        cmd_stall  = !((state_reg == dq_pkg::STATE_IDLE) && out_free);
        accept     = cmd_valid && !cmd_stall;
        is_full    = (count_reg == CNT_W'(DEPTH));
        is_empty   = (count_reg == '0);
        move       = rd_valid_reg && out_free;

        list_start = 1'b0;
        push_ok    = 1'b0;
        pop_ok     = 1'b0;
        stat_load  = 1'b0;
        stat_code  = dq_pkg::STAT_DONE;
        wr_en      = 1'b0;
        wr_addr    = tail_pos;
        rd_en      = 1'b0;
        rd_addr    = rd_ptr_reg;
        issue_last = 1'b0;

        if (accept)
        begin
            stat_load = 1'b1;
            case (cmd.action)
                dq_pkg::ACT_APPEND:
                begin
                    push_ok   = !is_full;
                    wr_en     = !is_full;
                    wr_addr   = tail_pos;
                    stat_code = is_full ? dq_pkg::STAT_FULL : dq_pkg::STAT_DONE;
                end
                dq_pkg::ACT_INSERT:
                begin
                    push_ok   = !is_full;
                    wr_en     = !is_full;
                    wr_addr   = head_dec;
                    stat_code = is_full ? dq_pkg::STAT_FULL : dq_pkg::STAT_DONE;
                end
                dq_pkg::ACT_REMOVE:
                begin
                    pop_ok    = !is_empty;
                    stat_code = is_empty ? dq_pkg::STAT_EMPTY : dq_pkg::STAT_DONE;
                end
                dq_pkg::ACT_LIST:
                begin
                    if (is_empty)
                    begin
                        stat_code = dq_pkg::STAT_NOLIST;
                    end
                    else
                    begin
                        stat_load  = 1'b0;
                        list_start = 1'b1;
                        rd_en      = 1'b1;
                        rd_addr    = head_reg;
                        issue_last = (count_reg == CNT_W'(1));
                    end
                end
                default:
                begin
                    stat_code = dq_pkg::STAT_DONE;
                end
            endcase
        end
        else if (state_reg == dq_pkg::STATE_LIST)
        begin
            rd_en      = (rem_reg != '0) && (!rd_valid_reg || move);
            rd_addr    = rd_ptr_reg;
            issue_last = (rem_reg == CNT_W'(1));
        end

        res_valid = out_valid_reg;
        res       = out_reg;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dq_pkg::STATE_IDLE:
            begin
                if (list_start)
                begin
                    state_next = dq_pkg::STATE_LIST;
                end
            end
            dq_pkg::STATE_LIST:
            begin
                if (move && rd_last_reg)
                begin
                    state_next = dq_pkg::STATE_IDLE;
                end
            end
            default:
            begin
                state_next = dq_pkg::STATE_IDLE;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        head_next     = head_reg;
        count_next    = count_reg;
        rd_ptr_next   = rd_ptr_reg;
        rem_next      = rem_reg;
        rd_valid_next = rd_valid_reg;
        rd_last_next  = rd_last_reg;
        out_next      = out_reg;
        out_valid_next = out_valid_reg && res_stall;

        if (push_ok)
        begin
            count_next = count_reg + CNT_W'(1);
            if (cmd.action == dq_pkg::ACT_INSERT)
            begin
                head_next = head_dec;
            end
        end
        if (pop_ok)
        begin
            count_next = count_reg - CNT_W'(1);
            head_next  = head_inc;
        end

        if (list_start)
        begin
            rem_next    = count_reg - CNT_W'(1);
            rd_ptr_next = head_inc;
        end
        else if (rd_en)
        begin
            rem_next    = rem_reg - CNT_W'(1);
            rd_ptr_next = rd_ptr_inc;
        end

        if (rd_en)
        begin
            rd_valid_next = 1'b1;
            rd_last_next  = issue_last;
        end
        else if (move)
        begin
            rd_valid_next = 1'b0;
        end

        if (move)
        begin
            out_next.out_value = rd_data;
            out_next.status    = dq_pkg::STAT_ELEMENT;
            out_next.last      = rd_last_reg;
            out_valid_next     = 1'b1;
        end
        else if (stat_load)
        begin
            out_next.out_value = '0;
            out_next.status    = stat_code;
            out_next.last      = 1'b1;
            out_valid_next     = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dq_pkg::STATE_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            rem_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            rem_reg       <= rem_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_ptr_reg  <= rd_ptr_next;
        rd_last_reg <= rd_last_next;
        out_reg     <= out_next;
    end

    `DQ_ASSERT_SAME(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(DEPTH))
    `DQ_ASSERT_SAME(a_list_blocks_cmd, clk, rst_n, state_reg == dq_pkg::STATE_LIST, cmd_stall)
    `DQ_ASSERT_NEXT(a_read_held, clk, rst_n, rd_valid_reg && !out_free, rd_valid_reg && $stable(rd_last_reg))
    `DQ_ASSERT_NEXT(a_push_count, clk, rst_n, push_ok, count_reg == $past(count_reg) + CNT_W'(1))

endmodule

`default_nettype wire

### rtl/core/dq_ram.sv
// ============================================================================
// dq_ram
// Generic single-write, single-read RAM with a registered read port.
// Read data holds while the read enable is low.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module dq_ram #(
    parameter int WIDTH = dq_pkg::DATA_W,
    parameter int DEPTH = dq_pkg::DEPTH_DEFAULT
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire
